>>> design/mar_pkg.sv
// Shared types and constants of the moving average ring.
// Used by every module of the block but mar_ram; depends on nothing.
`default_nettype none

package mar_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COUNT_OUT_W = 11;
  localparam int unsigned S_TDATA_W   = 16;
  localparam int unsigned M_TDATA_W   = 32;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_e;

  typedef struct packed {
    logic idle;
    logic busy;
    logic done;
  } back_status_t;

endpackage

`default_nettype wire

>>> design/moving_average_ring.sv
// Top level of the boxcar moving average over a ring of DEPTH samples.
// Depends on mar_pkg, mar_front, mar_queue and mar_back.
//
//   channel   dir   beat contents
//   s_axis    in    tdata[15:0] sample
//   m_axis    out   tdata[15:0] average, tdata[26:16] sample_count
//
// The bit-serial divider handles one beat at a time and sets the rate.
// The front end and a two-entry queue can absorb up to three further samples meanwhile.
// Reset clears the pointer, sum and fill count; ring entries beyond the fill count
// are treated as zero, so no clearing pass is needed.
// A stalled output beat holds in the output register while input fills the front end and queue.
`default_nettype none

module moving_average_ring #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [mar_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [15:0] sample
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [mar_pkg::M_TDATA_W-1:0]    m_axis_tdata   // [15:0] average, [26:16] count
);

  import mar_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = SAMPLE_W + PTR_W;
  localparam int unsigned Q_W   = SUM_W + CNT_W;

  logic                   f_push;
  logic                   q_ready;
  logic [SUM_W-1:0]       f_sum;
  logic [CNT_W-1:0]       f_cnt;
  logic                   q_valid;
  logic                   b_pop;
  logic [Q_W-1:0]         q_out;
  logic [SAMPLE_W-1:0]    avg;
  logic [COUNT_OUT_W-1:0] cnt_out;
  back_status_t           b_status;

  mar_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_sample_i   (s_axis_tdata[SAMPLE_W-1:0]),
    .push_o       (f_push),
    .push_ready_i (q_ready),
    .push_sum_o   (f_sum),
    .push_cnt_o   (f_cnt)
  );

  mar_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .ready_o (q_ready),
    .data_i  ({f_cnt, f_sum}),
    .valid_o (q_valid),
    .pop_i   (b_pop),
    .data_o  (q_out)
  );

  mar_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .pop_o     (b_pop),
    .q_sum_i   (q_out[SUM_W-1:0]),
    .q_cnt_i   (q_out[Q_W-1:SUM_W]),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_avg_o   (avg),
    .m_cnt_o   (cnt_out),
    .status_o  (b_status)
  );

  assign m_axis_tdata = {{(M_TDATA_W - SAMPLE_W - COUNT_OUT_W){1'b0}}, cnt_out, avg};

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_pop |-> q_valid)
    else $error("divider took an entry from an empty queue");

  a_accept_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> f_push)
    else $error("accepted sample did not reach the sum stage");

  a_div_runs_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_status.busy |=> (b_status.busy || b_status.done))
    else $error("division left its loop early");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(b_status.done))
    else $error("output beat raised without a finished division");

endmodule

`default_nettype wire

>>> design/mar_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Read during a write to the same address returns the old contents; no dependencies.
`default_nettype none

module mar_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire  [$clog2(DEPTH)-1:0]     waddr_i,
  input  wire  [WIDTH-1:0]             wdata_i,
  input  wire                          re_i,
  input  wire  [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> design/mar_front.sv
// Front end: accepts sample beats, keeps the ring, pointer, fill count and running sum.
// Depends on mar_pkg and mar_ram; hands each updated sum and count to the queue.
`default_nettype none

module mar_front #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_valid_i,
  output logic                                  s_ready_o,
  input  wire  [mar_pkg::SAMPLE_W-1:0]          s_sample_i,
  output logic                                  push_o,
  input  wire                                   push_ready_i,
  output logic [mar_pkg::SAMPLE_W+$clog2(DEPTH)-1:0] push_sum_o,
  output logic [$clog2(DEPTH+1)-1:0]            push_cnt_o
);

  import mar_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = SAMPLE_W + PTR_W;

  logic [PTR_W-1:0]    ptr_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    cnt_d;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    sum_d;
  logic                pend_q;
  logic [SAMPLE_W-1:0] pend_sample_q;
  logic                pend_old_q;
  logic [CNT_W-1:0]    pend_cnt_q;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] old_sample;
  logic                accept;
  logic                ring_full;

  assign s_ready_o = !pend_q || push_ready_i;
  assign accept    = s_valid_i && s_ready_o;
  assign ring_full = (cnt_q == CNT_W'(DEPTH));
  assign cnt_d     = ring_full ? cnt_q : cnt_q + CNT_W'(1);

  mar_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (ptr_q),
    .wdata_i (s_sample_i),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (rd_data)
  );

  // Entries beyond the fill count have not been written since reset and count as zero.
  assign old_sample = pend_old_q ? rd_data : '0;
  assign sum_d      = sum_q + {{PTR_W{pend_sample_q[SAMPLE_W-1]}}, pend_sample_q}
                            - {{PTR_W{old_sample[SAMPLE_W-1]}}, old_sample};

  assign push_o     = pend_q;
  assign push_sum_o = sum_d;
  assign push_cnt_o = pend_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (accept) begin
        ptr_q  <= (ptr_q == PTR_W'(DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
        cnt_q  <= cnt_d;
        pend_q <= 1'b1;
      end else if (push_ready_i) begin
        pend_q <= 1'b0;
      end
      if (pend_q && push_ready_i) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_sample_q <= s_sample_i;
      pend_old_q    <= ring_full;
      pend_cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> design/mar_queue.sv
// Two-entry queue that decouples the front end from the divider.
// Depends on mar_pkg.
`default_nettype none

module mar_queue #(
  parameter int unsigned WIDTH = 37
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  output logic              ready_o,
  input  wire  [WIDTH-1:0]  data_i,
  output logic              valid_o,
  input  wire               pop_i,
  output logic [WIDTH-1:0]  data_o
);

  import mar_pkg::*;

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       fill_q;
  logic             do_push;
  logic             do_pop;

  assign ready_o = (fill_q != 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/mar_back.sv
// Back end: bit-serial restoring divider of the window sum by the fill count,
// followed by the output register. Depends on mar_pkg.
`default_nettype none

module mar_back #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        q_valid_i,
  output logic                                       pop_o,
  input  wire  [mar_pkg::SAMPLE_W+$clog2(DEPTH)-1:0] q_sum_i,
  input  wire  [$clog2(DEPTH+1)-1:0]                 q_cnt_i,
  output logic                                       m_valid_o,
  input  wire                                        m_ready_i,
  output logic [mar_pkg::SAMPLE_W-1:0]               m_avg_o,
  output logic [mar_pkg::COUNT_OUT_W-1:0]            m_cnt_o,
  output mar_pkg::back_status_t                      status_o
);

  import mar_pkg::*;

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + PTR_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  back_state_e       state_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [SUM_W-1:0]  result;
  logic              load_out;

  assign pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign diff     = trial - {1'b0, div_q};
  assign ge       = (trial >= {1'b0, div_q});
  assign result   = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
  assign load_out = (state_q == ST_DONE) && (!m_valid_o || m_ready_i);

  assign status_o.idle = (state_q == ST_IDLE);
  assign status_o.busy = (state_q == ST_DIV);
  assign status_o.done = (state_q == ST_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      m_valid_o <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            state_q <= ST_DIV;
            step_q  <= '0;
          end
        end
        ST_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(SUM_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (load_out) begin
        m_valid_o <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q <= q_sum_i[SUM_W-1];
      quo_q <= q_sum_i[SUM_W-1] ? (~q_sum_i + SUM_W'(1)) : q_sum_i;
      rem_q <= '0;
      div_q <= q_cnt_i;
    end else if (state_q == ST_DIV) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
    if (load_out) begin
      m_avg_o <= result[SAMPLE_W-1:0];
      m_cnt_o <= COUNT_OUT_W'(div_q);
    end
  end

endmodule

`default_nettype wire

>>> test/moving_average_ring_test.sv
// Self-checking testbench of the boxcar moving average over a ring of 1024 samples.
// A scoreboard class predicts each average and count; tasks drive the input channel.
// Depends on mar_pkg and moving_average_ring.
`timescale 1ns / 1ps

module moving_average_ring_test;
  import mar_pkg::*;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned RANDOM_SAMPLES = 1700;
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [SAMPLE_W-1:0]    average;
    logic [COUNT_OUT_W-1:0] sample_count;
  } mean_beat_t;

  class window_mean_board;
    logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
    int unsigned                wr_ptr;
    int unsigned                fill;
    longint                     window_total;
    mean_beat_t                 pending[$];
    int unsigned                mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr       = 0;
      fill         = 0;
      window_total = 0;
      mismatches   = 0;
    endfunction

    function void note_failure(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void push_sample(logic signed [SAMPLE_W-1:0] sample);
      mean_beat_t beat;
      longint     quot;
      window_total += longint'(sample) - longint'(ring[wr_ptr]);
      ring[wr_ptr] = sample;
      wr_ptr = (wr_ptr == RING_DEPTH - 1) ? 0 : wr_ptr + 1;
      if (fill < RING_DEPTH) fill++;
      quot = window_total / longint'(fill);
      beat.average      = quot[SAMPLE_W-1:0];
      beat.sample_count = fill[COUNT_OUT_W-1:0];
      pending.push_back(beat);
    endfunction

    function void check_beat(logic [M_TDATA_W-1:0] tdata);
      mean_beat_t want;
      logic [SAMPLE_W-1:0]    got_avg;
      logic [COUNT_OUT_W-1:0] got_count;
      got_avg   = tdata[SAMPLE_W-1:0];
      got_count = tdata[SAMPLE_W +: COUNT_OUT_W];
      if (pending.size() == 0) begin
        note_failure($sformatf("unexpected beat, average %0d count %0d",
                               $signed(got_avg), got_count));
      end else begin
        want = pending.pop_front();
        if (got_avg !== want.average || got_count !== want.sample_count)
          note_failure($sformatf("expected average %0d count %0d, got average %0d count %0d",
                                 $signed(want.average), want.sample_count,
                                 $signed(got_avg), got_count));
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;  // [15:0] sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;  // [15:0] average, [26:16] sample count

  window_mean_board board;
  int unsigned      burst_left;
  int unsigned      rx_cycle;
  int unsigned      rx_mode;
  int unsigned      rx_period;
  int unsigned      rx_stall;

  moving_average_ring #(.DEPTH(RING_DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver switches between always ready, random stalls and a periodic stall.
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) begin
      rx_mode   = $urandom_range(0, 2);
      rx_period = $urandom_range(2, 12);
      rx_stall  = $urandom_range(1, rx_period - 1);
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ((rx_cycle % rx_period) >= rx_stall);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata);
  end

  task automatic offer_sample(input logic [SAMPLE_W-1:0] sample);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready);
    board.push_sample(sample);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] directed [$];
    int unsigned sent;
    int unsigned run_kind;
    int unsigned run_len;
    logic [SAMPLE_W-1:0] held;
    logic [SAMPLE_W-1:0] value;
    board         = new();
    burst_left    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Truncation toward zero, full-scale runs of both signs, and alternating bit patterns.
    directed = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0002, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'hFFFD,
                 16'h5555, 16'hAAAA, 16'h0000, 16'h7FFF, 16'h8000, 16'h0003};
    foreach (directed[i]) offer_sample(directed[i]);
    drain_results();

    // Runs of random, extreme, small and alternating samples, filling and wrapping the ring.
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      run_kind = $urandom_range(0, 3);
      run_len  = (run_kind == 1) ? $urandom_range(1, 300) : $urandom_range(1, 80);
      held     = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      for (int unsigned k = 0; k < run_len && sent < RANDOM_SAMPLES; k++) begin
        case (run_kind)
          0: value = SAMPLE_W'($urandom());
          1: value = held;
          2: value = SAMPLE_W'($urandom_range(0, 8) - 4);
          default: value = k[0] ? 16'h7FFF : 16'h8000;
        endcase
        offer_sample(value);
        sent++;
        if (sent == RANDOM_SAMPLES / 2) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.pending.size() != 0)
      board.note_failure($sformatf("%0d results never arrived", board.pending.size()));
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
